[rtl/bqbp_pkg.sv]
// Shared types, constants and helper functions for the biquad band-pass cascade.
// Holds the fixed Q2.28 coefficient table and the saturation helpers.
// Depends on nothing.
package bqbp_pkg;

  localparam int SampleW = 12;
  localparam int FiltW   = 22;
  localparam int DlyW    = 40;
  localparam int FracW   = 16;
  localparam int CoefW   = 31;
  localparam int HalfW   = 20;
  localparam int OpW     = DlyW - HalfW + 1;
  localparam int MulW    = CoefW + OpW;
  localparam int PaccW   = 72;
  localparam int RndSh   = 28;
  localparam int RndW    = PaccW - RndSh;
  localparam int AccW    = 46;
  localparam int MaxSect = 8;
  localparam int StepW   = 4;

  typedef logic signed [DlyW-1:0]  dly_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [FiltW-1:0] filt_t;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFinish
  } state_e;

  typedef enum logic [2:0] {
    CoefB0,
    CoefB1,
    CoefB2,
    CoefA1,
    CoefA2
  } coef_sel_e;

  localparam coef_t CoefTab [MaxSect][5] = '{
    '{31'sd9936635,   31'sd19873270,   31'sd9936635,
      -31'sd114394435, 31'sd22253807},
    '{31'sd268435456, 31'sd536870912,  31'sd268435456,
      -31'sd152163503, 31'sd129838386},
    '{31'sd268435456, -31'sd536870912, 31'sd268435456,
      -31'sd530584935, 31'sd262192753},
    '{31'sd268435456, -31'sd536870912, 31'sd268435456,
      -31'sd534293338, 31'sd265900298},
    '{31'sd268435456, 31'sd0, 31'sd0, 31'sd0, 31'sd0},
    '{31'sd268435456, 31'sd0, 31'sd0, 31'sd0, 31'sd0},
    '{31'sd268435456, 31'sd0, 31'sd0, 31'sd0, 31'sd0},
    '{31'sd268435456, 31'sd0, 31'sd0, 31'sd0, 31'sd0}
  };

  function automatic coef_t coef_f(input logic [2:0] sect, input coef_sel_e sel);
    coef_t c;
    c = '0;
    unique case (sel)
      CoefB0:  c = CoefTab[sect][0];
      CoefB1:  c = CoefTab[sect][1];
      CoefB2:  c = CoefTab[sect][2];
      CoefA1:  c = CoefTab[sect][3];
      CoefA2:  c = CoefTab[sect][4];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic dly_t sat_dly_f(input acc_t v);
    dly_t r;
    if (&v[AccW-1:DlyW-1] || ~|v[AccW-1:DlyW-1]) begin
      r = v[DlyW-1:0];
    end else if (v[AccW-1]) begin
      r = {1'b1, {(DlyW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DlyW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic filt_t out_f(input dly_t v);
    logic signed [DlyW:0] t;
    filt_t r;
    t = {v[DlyW-1], v} + (DlyW+1)'(128);
    if (&t[DlyW:FiltW+7] || ~|t[DlyW:FiltW+7]) begin
      r = t[FiltW+7:8];
    end else if (t[DlyW]) begin
      r = {1'b1, {(FiltW-1){1'b0}}};
    end else begin
      r = {1'b0, {(FiltW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/biquad_cascade_bandpass.sv]
// Top level of the biquad band-pass cascade: sequencer, shared multiplier and delay lines.
// Depends on bqbp_pkg for the coefficient table, types and saturation helpers.
//
//   Channel | Handshake                  | Payload
//   input   | in_valid_i / in_ready_o    | sample_i   (12 bit unsigned)
//   output  | out_valid_o / out_ready_i  | filtered_o (22 bit signed, 8 fraction bits)
//
// Each beat runs through the sections one after another, and the next beat is not taken
// before the last one has left the sequencer. Every product is formed by the single
// 31 x 21 bit multiplier, which handles it in two halves.
// Reset clears all section delays to zero and empties the output register.
// A new beat is taken as soon as the sequencer is idle, even while a result waits.
// A result stalled at the output holds the next finished beat back until it is taken.
module biquad_cascade_bandpass #(
  parameter int SECTIONS    = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bqbp_pkg::SampleW-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [bqbp_pkg::FiltW-1:0] filtered_o
);

  import bqbp_pkg::*;

  localparam int SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [SecW-1:0] SecLast = SecW'(SECTIONS - 1);
  localparam logic [SampleW-1:0] SampleMask =
    (SAMPLE_BITS >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << SAMPLE_BITS) - 1);
  localparam logic signed [PaccW-1:0] PaccRnd = PaccW'(1) <<< (RndSh - 1);

  localparam logic [StepW-1:0] StepA1Lo  = 4'd0;
  localparam logic [StepW-1:0] StepA1Hi  = 4'd1;
  localparam logic [StepW-1:0] StepA2Lo  = 4'd2;
  localparam logic [StepW-1:0] StepA2Hi  = 4'd3;
  localparam logic [StepW-1:0] StepB1Lo  = 4'd4;
  localparam logic [StepW-1:0] StepB1Hi  = 4'd5;
  localparam logic [StepW-1:0] StepB2Lo  = 4'd6;
  localparam logic [StepW-1:0] StepB2Hi  = 4'd7;
  localparam logic [StepW-1:0] StepB0Lo  = 4'd8;
  localparam logic [StepW-1:0] StepB0Hi  = 4'd9;
  localparam logic [StepW-1:0] StepLastY = 4'd10;
  localparam logic [StepW-1:0] StepShift = 4'd11;

  state_e state_q, state_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  filt_t            filtered_q;

  dly_t z1_q [SECTIONS];
  dly_t z2_q [SECTIONS];
  dly_t v_q;
  dly_t x_q;
  acc_t xacc_q;
  acc_t yacc_q;
  logic signed [MulW-1:0]  mul_q, mul_d;
  logic signed [PaccW-1:0] pacc_q;

  coef_sel_e               coef_sel;
  coef_t                   coef;
  dly_t                    mul_src;
  logic signed [OpW-1:0]   mul_op;
  logic signed [PaccW-1:0] psum;
  logic signed [RndW-1:0]  rnd;

  logic accept;
  logic load_out;
  logic x_add;
  logic y_add;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  always_comb begin
    coef_sel = CoefB0;
    mul_src  = x_q;
    x_add    = 1'b0;
    y_add    = 1'b0;
    unique case (step_q)
      StepA1Lo, StepA1Hi: begin
        coef_sel = CoefA1;
        mul_src  = z1_q[0];
      end
      StepA2Lo, StepA2Hi: begin
        coef_sel = CoefA2;
        mul_src  = z2_q[0];
        x_add    = (step_q == StepA2Lo);
      end
      StepB1Lo, StepB1Hi: begin
        coef_sel = CoefB1;
        mul_src  = z1_q[0];
        x_add    = (step_q == StepB1Lo);
      end
      StepB2Lo, StepB2Hi: begin
        coef_sel = CoefB2;
        mul_src  = z2_q[0];
        y_add    = (step_q == StepB2Lo);
      end
      StepB0Lo, StepB0Hi: begin
        coef_sel = CoefB0;
        mul_src  = x_q;
        y_add    = (step_q == StepB0Lo);
      end
      StepLastY: begin
        y_add = 1'b1;
      end
      default: begin
        coef_sel = CoefB0;
      end
    endcase
  end

  assign coef   = coef_f(3'(sec_q), coef_sel);
  assign mul_op = step_q[0] ? {mul_src[DlyW-1], mul_src[DlyW-1:HalfW]}
                            : $signed({1'b0, mul_src[HalfW-1:0]});
  assign mul_d  = MulW'(coef) * MulW'(mul_op);
  assign psum   = pacc_q + (PaccW'(mul_q) <<< HalfW);
  assign rnd    = psum[PaccW-1:RndSh];

  always_comb begin
    state_d     = state_q;
    sec_d       = sec_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRun;
          sec_d   = '0;
          step_d  = StepA1Lo;
        end
      end
      StRun: begin
        if (step_q == StepShift) begin
          step_d = StepA1Lo;
          if (sec_q == SecLast) begin
            state_d = StFinish;
          end else begin
            sec_d = sec_q + SecW'(1);
          end
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sec_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        z1_q[i] <= '0;
        z2_q[i] <= '0;
      end
    end else if (state_q == StRun && step_q == StepShift) begin
      for (int i = 0; i < SECTIONS - 1; i++) begin
        z1_q[i] <= z1_q[i+1];
        z2_q[i] <= z2_q[i+1];
      end
      z1_q[SECTIONS-1] <= x_q;
      z2_q[SECTIONS-1] <= z1_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q <= DlyW'({sample_i & SampleMask, {FracW{1'b0}}});
    end else if (state_q == StRun && step_q == StepShift) begin
      v_q <= sat_dly_f(yacc_q);
    end
    if (state_q == StRun) begin
      mul_q <= mul_d;
      if (step_q[0]) begin
        pacc_q <= PaccW'(mul_q) + PaccRnd;
      end
      if (step_q == StepA1Lo) begin
        xacc_q <= AccW'(v_q);
        yacc_q <= '0;
      end else if (x_add) begin
        xacc_q <= xacc_q - AccW'(rnd);
      end else if (y_add) begin
        yacc_q <= yacc_q + AccW'(rnd);
      end
      if (step_q == StepB1Hi) begin
        x_q <= sat_dly_f(xacc_q);
      end
    end
    if (load_out) begin
      filtered_q <= out_f(v_q);
    end
  end

endmodule

[bench/biquad_cascade_bandpass_tb.sv]
// Self-checking bench for biquad_cascade_bandpass: a queue-fed driver, a monitor and a
// bit-exact fixed-point model of the four-section band-pass cascade.
// Depends on bqbp_pkg for the port types and on the RTL of the block.
module biquad_cascade_bandpass_tb;

  typedef logic signed [95:0] wide_t;
  typedef enum int {PatNoise, PatWalk, PatSquare, PatRail, PatRamp} pattern_e;

  localparam int    NumSect     = 4;
  localparam int    SampleMax   = 4095;
  localparam int    Latency     = 12 * NumSect + 2;
  localparam int    HoldCycles  = 600;
  localparam int    WatchLimit  = 5000;
  localparam wide_t RoundHalf   = 96'sd134217728;
  localparam wide_t DlyHi       = (96'sd1 <<< 39) - 96'sd1;
  localparam wide_t DlyLo       = -(96'sd1 <<< 39);
  localparam wide_t FiltHi      = 96'sd2097151;
  localparam wide_t FiltLo      = -96'sd2097152;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [bqbp_pkg::SampleW-1:0] sample_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  bqbp_pkg::filt_t        filtered_o;

  logic [bqbp_pkg::SampleW-1:0] pending_samples[$];
  bqbp_pkg::filt_t              expected_filtered[$];
  bqbp_pkg::dly_t               chain_z[2*NumSect];
  longint                       coef_q28[NumSect][5];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int samples_in = 0;
  int results_out = 0;

  wire in_fire  = in_valid_i && in_ready_o;
  wire out_fire = out_valid_o && out_ready_i;

  biquad_cascade_bandpass DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint q28_of(input longint hundred_millionths);
    longint mag;
    longint r;
    mag = (hundred_millionths < 0) ? -hundred_millionths : hundred_millionths;
    r = (mag * 64'sd268435456 + 64'sd50000000) / 64'sd100000000;
    return (hundred_millionths < 0) ? -r : r;
  endfunction

  function automatic wide_t scale_q28(input longint c, input bqbp_pkg::dly_t d);
    wide_t p;
    p = wide_t'(c) * wide_t'(d) + RoundHalf;
    return p >>> 28;
  endfunction

  function automatic bqbp_pkg::dly_t clip_delay(input wide_t v);
    wide_t r;
    r = (v > DlyHi) ? DlyHi : ((v < DlyLo) ? DlyLo : v);
    return r[39:0];
  endfunction

  function automatic bqbp_pkg::filt_t run_cascade(input logic [bqbp_pkg::SampleW-1:0] s);
    wide_t          v;
    wide_t          r;
    bqbp_pkg::dly_t z1;
    bqbp_pkg::dly_t z2;
    bqbp_pkg::dly_t xs;
    v = wide_t'({1'b0, s}) <<< 16;
    for (int k = 0; k < NumSect; k++) begin
      z1 = chain_z[2*k];
      z2 = chain_z[2*k+1];
      xs = clip_delay(v - scale_q28(coef_q28[k][bqbp_pkg::CoefA1], z1)
                        - scale_q28(coef_q28[k][bqbp_pkg::CoefA2], z2));
      v = wide_t'(clip_delay(scale_q28(coef_q28[k][bqbp_pkg::CoefB0], xs)
                           + scale_q28(coef_q28[k][bqbp_pkg::CoefB1], z1)
                           + scale_q28(coef_q28[k][bqbp_pkg::CoefB2], z2)));
      chain_z[2*k+1] = z1;
      chain_z[2*k]   = xs;
    end
    r = (v + 96'sd128) >>> 8;
    r = (r > FiltHi) ? FiltHi : ((r < FiltLo) ? FiltLo : r);
    return r[21:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_sample(input int v);
    pending_samples.push_back(v[bqbp_pkg::SampleW-1:0]);
  endtask

  task automatic fill_random(input int n);
    int       left;
    int       len;
    int       level;
    int       stride;
    int       period;
    int       lo;
    int       hi;
    pattern_e pat;
    left = n;
    while (left > 0) begin
      pat = pattern_e'($urandom_range(4, 0));
      len = $urandom_range(60, 8);
      if (len > left) len = left;
      level  = $urandom_range(SampleMax, 0);
      stride = $urandom_range(200, 1);
      period = $urandom_range(40, 2);
      lo     = $urandom_range(SampleMax, 0);
      hi     = $urandom_range(SampleMax, 0);
      for (int i = 0; i < len; i++) begin
        case (pat)
          PatNoise: push_sample($urandom_range(SampleMax, 0));
          PatWalk: begin
            level += $urandom_range(2 * stride, 0) - stride;
            if (level < 0) level = 0;
            if (level > SampleMax) level = SampleMax;
            push_sample(level);
          end
          PatSquare: push_sample(((i / period) % 2 == 0) ? lo : hi);
          PatRail:   push_sample($urandom_range(1, 0) ? SampleMax : 0);
          default: begin
            level = (level + stride) % (SampleMax + 1);
            push_sample(level);
          end
        endcase
      end
      left -= len;
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid_i || expected_filtered.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    fill_random(n);
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else begin
      if (in_fire) begin
        expected_filtered.push_back(run_cascade(sample_i));
        samples_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bqbp_pkg::filt_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_fire) begin
        results_out++;
        if (expected_filtered.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with nothing expected", results_out));
        end else begin
          want = expected_filtered.pop_front();
          if (filtered_o !== want) begin
            report_mismatch($sformatf("beat %0d filtered got %0d expected %0d",
                                      results_out, filtered_o, want));
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchLimit) begin
        $display("Timeout after %0d cycles without a beat", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    longint const_tab[NumSect][5];
    const_tab[0] = '{3701685, 7403370, 3701685, -42615248, 8290189};
    const_tab[1] = '{100000000, 200000000, 100000000, -56685322, 48368568};
    const_tab[2] = '{100000000, -200000000, 100000000, -197658291, 97674412};
    const_tab[3] = '{100000000, -200000000, 100000000, -199039779, 99055580};
    for (int k = 0; k < NumSect; k++) begin
      for (int j = 0; j < 5; j++) coef_q28[k][j] = q28_of(const_tab[k][j]);
      chain_z[2*k]   = '0;
      chain_z[2*k+1] = '0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A step from rest, a full-scale step, mid-scale and near-rail values, then alternation between the rails.
    repeat (5) push_sample(0);
    repeat (4) push_sample(SampleMax);
    push_sample(2048);
    push_sample(2047);
    push_sample(1);
    push_sample(SampleMax - 1);
    for (int i = 0; i < 10; i++) push_sample((i % 2) ? SampleMax : 0);
    wait_drained();

    @(negedge clk_i);
    fill_random(350);
    repeat (5) @(negedge clk_i);
    hold_req = hold_req + 1;
    wait_drained();

    run_phase(64, 0, 350);
    run_phase(0, 64, 350);
    run_phase(24, 24, 350);

    repeat (Latency + 20) @(negedge clk_i);
    if (expected_filtered.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_filtered.size()));

    $display("Sent %0d samples and checked %0d filtered beats across four pacing phases,",
             samples_in, results_out);
    $display("including %0d long output hold-off with the input kept busy.", hold_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
